@@ design/vflt_pkg.sv @@
// vflt_pkg: shared types and constants for the video frame loss tracker.
// No dependencies.
package vflt_pkg;

  localparam int SEQ_BITS = 16;
  localparam int ENC_BITS = 24;

  localparam logic [1:0] KIND_I   = 2'd0;
  localparam logic [1:0] KIND_IDR = 2'd1;
  localparam logic [1:0] KIND_P   = 2'd2;
  localparam logic [1:0] KIND_B   = 2'd3;

  localparam logic [1:0] CFG_NB  = 2'd0;
  localparam logic [1:0] CFG_GOP = 2'd1;
  localparam logic [1:0] CFG_TFC = 2'd2;

  // shared divider operations
  localparam logic [1:0] OP_FDIV = 2'd0;  // frame / (B + 1)
  localparam logic [1:0] OP_GOP  = 2'd1;  // next anchor % gop
  localparam logic [1:0] OP_TFC  = 2'd2;  // |encoding + 1| % trace frame count

  typedef struct packed {
    logic start;
    logic op_sel;
  } div_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

@@ design/vflt_div.sv @@
// vflt_div: shared restoring divider, one quotient bit per cycle.
// Depends on vflt_pkg.
module vflt_div import vflt_pkg::*; #(
  parameter int W = 24
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quot,
  output logic [W-1:0] rem
);

  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  q_r, q_nxt;
  logic [W:0]    r_r, r_nxt;
  logic [W-1:0]  d_r, d_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          run_r, run_nxt;
  logic          done_r, done_nxt;
  logic [W:0]    trial;

  always_comb begin
    q_nxt = q_r; r_nxt = r_r; d_nxt = d_r; cnt_nxt = cnt_r;
    run_nxt = run_r; done_nxt = 1'b0;
    trial = {r_r[W-1:0], q_r[W-1]};
    if (start) begin
      q_nxt = dividend; r_nxt = '0; d_nxt = divisor;
      cnt_nxt = CW'(W); run_nxt = 1'b1;
    end else if (run_r) begin
      if (trial >= {1'b0, d_r}) begin
        r_nxt = trial - {1'b0, d_r};
        q_nxt = {q_r[W-2:0], 1'b1};
      end else begin
        r_nxt = trial;
        q_nxt = {q_r[W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        run_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt; r_r <= r_nxt; d_r <= d_nxt; cnt_r <= cnt_nxt;
    if (!rst_n) begin
      run_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r <= run_nxt;
      done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign quot = q_r;
  assign rem  = r_r[W-1:0];

endmodule

@@ design/vflt_ctrl.sv @@
// vflt_ctrl: sequencer for one packet: runs the divides it needs, then updates, then holds result.
// Depends on vflt_pkg.
module vflt_ctrl import vflt_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_fire,
  input  logic       need_div,
  input  logic       need_mod,
  input  logic       div_done,
  input  logic       out_fire,
  output logic       busy,
  output logic       div_start,
  output logic [1:0] div_op,
  output logic       cap,
  output logic       upd,
  output logic       out_vld
);

  typedef enum logic [3:0] {
    S_IDLE, S_D0, S_W0, S_D1, S_W1, S_D2, S_W2, S_UPD, S_OUT
  } st_t;
  st_t st_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
    end else begin
      case (st_r)
        S_IDLE: if (in_fire) st_r <= S_D0;
        S_D0: st_r <= need_div ? S_W0 : (need_mod ? S_D2 : S_UPD);
        S_W0: if (div_done) st_r <= S_D1;
        S_D1: st_r <= S_W1;
        S_W1: if (div_done) st_r <= need_mod ? S_D2 : S_UPD;
        S_D2: st_r <= S_W2;
        S_W2: if (div_done) st_r <= S_UPD;
        S_UPD: st_r <= S_OUT;
        S_OUT: if (out_fire) st_r <= S_IDLE;
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign busy = (st_r != S_IDLE);
  assign cap = in_fire;
  assign div_start = (st_r == S_D0 && need_div) || st_r == S_D1 || st_r == S_D2;
  assign div_op = (st_r == S_D1 || st_r == S_W1) ? OP_GOP :
                  (st_r == S_D2 || st_r == S_W2) ? OP_TFC : OP_FDIV;
  assign upd = (st_r == S_UPD);
  assign out_vld = (st_r == S_OUT);

endmodule

@@ design/vflt_dp.sv @@
// vflt_dp: tracker state, B-frame dependency math and saturating counters.
// Depends on vflt_pkg and vflt_div.
module vflt_dp import vflt_pkg::*; #(
  parameter int FRAME_NUM_BITS = 20,
  parameter int COUNTER_BITS   = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cap,
  input  logic                      upd,
  input  logic                      div_start,
  input  logic [1:0]                div_op,
  output logic                      div_done,
  output logic                      need_div,
  output logic                      need_mod,
  input  logic [SEQ_BITS-1:0]       seq_in,
  input  logic                      fs_in,
  input  logic                      fe_in,
  input  logic [FRAME_NUM_BITS-1:0] fn_in,
  input  logic [1:0]                kind_in,
  input  logic                      warm_in,
  input  logic                      cfg_we,
  input  logic [1:0]                cfg_idx,
  input  logic [31:0]               cfg_val,
  output logic [31:0]               o_prx,
  output logic [31:0]               o_plost,
  output logic [31:0]               o_frx,
  output logic [31:0]               o_fdrop,
  output logic [15:0]               o_lpk,
  output logic [19:0]               o_lfr,
  output logic                      o_trk
);

  localparam int EW = FRAME_NUM_BITS + 3;
  localparam int CB = COUNTER_BITS;
  localparam int DW = (FRAME_NUM_BITS + 2 > 21) ? FRAME_NUM_BITS + 2 : 21;

  typedef logic signed [EW-1:0] enc_t;

  logic [3:0]  nb_r;
  logic [10:0] gop_r;
  logic [20:0] tfc_r;

  logic [SEQ_BITS-1:0]       seq_r, last_seq_r;
  logic                      fs_r, fe_r, warm_r;
  logic [FRAME_NUM_BITS-1:0] fn_r;
  logic [1:0]                kind_r, ckind_r;
  logic                      synced_r, done_r, drop_r;
  enc_t                      lgi_r, lgp_r, cfn_r, cenc_r;
  logic [CB-1:0]             prx_r, plost_r, frx_r, fdrop_r;
  logic [15:0]               lpk_r;
  logic [19:0]               lfr_r;
  logic [DW-1:0]             last_r;
  logic [DW-1:0]             modr_r;

  enc_t fn_s, nb_s, enc, fn_nb1, last_s, next_s, mod_c, top, dd, cp1;
  logic [DW+1:0] lost_fr;
  logic [15:0]   lost_pk;
  logic          ok, gap;
  logic [EW-1:0] absv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nb_r <= 4'd2; gop_r <= 11'd12; tfc_r <= 21'd1048576;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_NB:  nb_r  <= cfg_val[3:0];
        CFG_GOP: gop_r <= cfg_val[10:0];
        CFG_TFC: tfc_r <= cfg_val[20:0];
        default: ;
      endcase
    end
  end

  logic [DW-1:0] dvd, dvs, quo, rmd;
  logic [DW-1:0] next_w;
  assign next_w = last_r + DW'(nb_r) + DW'(1);

  always_comb begin
    case (div_op)
      OP_GOP: begin
        dvd = next_w;
        dvs = (gop_r == 11'd0) ? DW'(1) : DW'(gop_r);
      end
      OP_TFC: begin
        dvd = DW'(absv);
        dvs = (tfc_r == 21'd0) ? DW'(1) : DW'(tfc_r);
      end
      default: begin
        dvd = DW'(fn_r);
        dvs = DW'(nb_r) + DW'(1);
      end
    endcase
  end

  vflt_div #(.W(DW)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(dvd), .divisor(dvs),
    .done(div_done), .quot(quo), .rem(rmd)
  );

  logic [DW-1:0] prod;
  assign prod = DW'(quo * (DW'(nb_r) + DW'(1)));

  logic gop_zero_r;
  always_ff @(posedge clk) begin
    if (div_done) begin
      case (div_op)
        OP_GOP:  gop_zero_r <= (rmd == '0);
        OP_TFC:  modr_r <= rmd;
        default: last_r <= prod;
      endcase
    end
  end

  assign need_div = synced_r && fs_r && (kind_r == KIND_B);
  assign need_mod = synced_r && gap;

  function automatic logic [CB-1:0] sat(input logic [CB-1:0] a, input logic [DW+1:0] b);
    logic [CB+DW+2:0] s;
    s = (CB+DW+3)'(a) + (CB+DW+3)'(b);
    return (s > (CB+DW+3)'({CB{1'b1}})) ? '1 : s[CB-1:0];
  endfunction

  always_comb begin
    fn_s = enc_t'(fn_r);
    nb_s = enc_t'(nb_r);
    if (kind_r == KIND_B) enc = fn_s + enc_t'(1);
    else if (kind_r == KIND_P) enc = fn_s - nb_s;
    else enc = (fn_s == 0) ? enc_t'(0) : fn_s - nb_s;
    fn_nb1 = fn_s - nb_s - enc_t'(1);
    last_s = enc_t'(last_r);
    next_s = enc_t'(next_w);
    cp1 = cenc_r + enc_t'(1);
    // remainder of |cp1| comes from the divider, sign follows the dividend
    absv = cp1[EW-1] ? -cp1 : cp1;
    mod_c = cp1[EW-1] ? -enc_t'(modr_r) : enc_t'(modr_r);
    top = (enc > cenc_r) ? enc : cenc_r;
    dd = top - cenc_r - enc_t'(1);
    ok = 1'b1;
    if (kind_r == KIND_P) ok = (lgi_r == fn_nb1) || (lgp_r == fn_nb1);
    else if (kind_r == KIND_B)
      ok = gop_zero_r ? (lgp_r == last_s && lgi_r == next_s) : (lgp_r == next_s);
    gap = (seq_r != last_seq_r + 16'd1);
    lost_pk = 16'd0;
    lost_fr = '0;
    if (gap) begin
      lost_pk = (seq_r > last_seq_r) ? seq_r - last_seq_r : 16'd1;
      if (enc > mod_c && dd > 0) lost_fr = (DW+2)'(dd);
      if (!done_r) lost_fr = lost_fr + 1'b1;
    end
    if (fs_r ? (fe_r && !ok) : (fe_r && (drop_r || (gap && !fs_r))))
      lost_fr = lost_fr + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (cap) begin
      seq_r <= seq_in; fs_r <= fs_in; fe_r <= fe_in; fn_r <= fn_in;
      kind_r <= kind_in; warm_r <= warm_in;
    end
    if (!rst_n) begin
      synced_r <= 1'b0; last_seq_r <= '0; lgi_r <= enc_t'(-1); lgp_r <= enc_t'(-1);
      cfn_r <= '0; cenc_r <= '0; ckind_r <= '0; done_r <= 1'b1; drop_r <= 1'b0;
      prx_r <= '0; plost_r <= '0; frx_r <= '0; fdrop_r <= '0;
      lpk_r <= '0; lfr_r <= '0;
    end else if (upd) begin
      lpk_r <= '0; lfr_r <= '0;
      if (!synced_r) begin
        if (warm_r && kind_r[1] == 1'b0 && fs_r) begin
          last_seq_r <= seq_r;
          lgp_r <= (fn_s > 0) ? fn_nb1 : enc_t'(-1);
          cfn_r <= fn_s; cenc_r <= enc; ckind_r <= kind_r;
          if (fe_r) begin
            done_r <= 1'b1; lgi_r <= fn_s; frx_r <= sat(frx_r, (DW+2)'(1));
          end else begin
            drop_r <= 1'b0; done_r <= 1'b0; lgi_r <= enc_t'(-1);
          end
          prx_r <= sat(prx_r, (DW+2)'(1));
          synced_r <= 1'b1;
        end
      end else begin
        last_seq_r <= seq_r;
        if (fs_r) begin
          drop_r <= !ok;
          done_r <= fe_r;
          if (fe_r && ok) begin
            if (kind_r[1] == 1'b0) lgi_r <= fn_s;
            else if (kind_r == KIND_P) lgp_r <= fn_s;
          end
          cfn_r <= fn_s; cenc_r <= enc; ckind_r <= kind_r;
        end else begin
          if (gap) drop_r <= 1'b1;
          if (fe_r) begin
            if (!(drop_r || gap)) begin
              if (kind_r[1] == 1'b0) lgi_r <= cfn_r;
              else if (kind_r == KIND_P) lgp_r <= cfn_r;
            end
            done_r <= 1'b1;
          end
        end
        if (fe_r && (fs_r ? ok : !(drop_r || gap))) frx_r <= sat(frx_r, (DW+2)'(1));
        prx_r <= sat(prx_r, (DW+2)'(1));
        plost_r <= sat(plost_r, (DW+2)'(lost_pk));
        fdrop_r <= sat(fdrop_r, lost_fr);
        lpk_r <= lost_pk;
        lfr_r <= (lost_fr > (DW+2)'(20'hFFFFF)) ? 20'hFFFFF : lost_fr[19:0];
      end
    end
  end

  assign o_prx = 32'(prx_r);
  assign o_plost = 32'(plost_r);
  assign o_frx = 32'(frx_r);
  assign o_fdrop = 32'(fdrop_r);
  assign o_lpk = lpk_r;
  assign o_lfr = lfr_r;
  assign o_trk = synced_r;

endmodule

@@ design/video_frame_loss_tracker_unit.sv @@
// video_frame_loss_tracker_unit: top level, stream ports and controller/datapath.
// Depends on vflt_pkg, vflt_ctrl, vflt_dp.
// One packet is in flight at a time; with out_tready high a plain packet passes
// through states D0, UPD and OUT from acceptance to the next acceptance. The
// shared bit-serial divider (DW = max(FRAME_NUM_BITS+2, 21) bits, 22 at the
// default) sets the rest: while tracking, a B-frame start fragment adds a divide
// for frame/(B+1) and one for the GOP modulo, and a sequence gap adds one for the
// encoding-order modulo. The result is held on out_ until taken. Registers are
// written only while idle; a pending register write takes precedence over an
// input word.
module video_frame_loss_tracker_unit import vflt_pkg::*; #(
  parameter int FRAME_NUM_BITS = 20,
  parameter int COUNTER_BITS   = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // seq_number[15:0], fragment_start[16], fragment_end[17], frame_number[37:18],
  // frame_type[39:38], warmup_passed[40]
  input  logic [47:0]  in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // packets_received, packets_lost, frames_received, frames_discarded (32 each),
  // lost_packets_now[143:128], lost_frames_now[163:144], tracking[164]
  output logic [167:0] out_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  logic busy, dstart, cap, upd, ovld, need_div, need_mod, ddone;
  logic [1:0] dop;
  logic [31:0] prx, plost, frx, fdrop;
  logic [15:0] lpk;
  logic [19:0] lfr;
  logic trk;

  assign in_tready = rst_n && !busy && !cfg_valid;
  assign cfg_ready = rst_n && !busy;

  vflt_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_tvalid && in_tready), .need_div(need_div),
    .need_mod(need_mod), .div_done(ddone), .out_fire(out_tvalid && out_tready),
    .busy(busy), .div_start(dstart), .div_op(dop), .cap(cap), .upd(upd), .out_vld(ovld)
  );

  vflt_dp #(.FRAME_NUM_BITS(FRAME_NUM_BITS), .COUNTER_BITS(COUNTER_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cap(cap), .upd(upd), .div_start(dstart),
    .div_op(dop), .div_done(ddone), .need_div(need_div), .need_mod(need_mod),
    .seq_in(in_tdata[15:0]), .fs_in(in_tdata[16]), .fe_in(in_tdata[17]),
    .fn_in(FRAME_NUM_BITS'(in_tdata[37:18])), .kind_in(in_tdata[39:38]),
    .warm_in(in_tdata[40]),
    .cfg_we(cfg_valid && cfg_ready), .cfg_idx(cfg_index), .cfg_val(cfg_data),
    .o_prx(prx), .o_plost(plost), .o_frx(frx), .o_fdrop(fdrop),
    .o_lpk(lpk), .o_lfr(lfr), .o_trk(trk)
  );

  assign out_tvalid = ovld;
  assign out_tdata = {3'b000, trk, lfr, lpk, fdrop, frx, plost, prx};

`ifndef SYNTHESIS
  a_no_in_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("input taken while result pending");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");
  a_track_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    $past(out_tdata[164]) && $past(rst_n) |-> out_tdata[164])
    else $error("tracking dropped");
`endif

endmodule

@@ verif/tb_top.sv @@
// tb_top: stream-level testbench for video_frame_loss_tracker_unit, with an in-line predictor
// of the loss counters, a scoreboard and random packet streams. Depends on vflt_pkg and the DUT.
`timescale 1ns / 1ps
module tb_top import vflt_pkg::*;;

  typedef struct packed {
    logic [31:0] pkts_rx;
    logic [31:0] pkts_lost;
    logic [31:0] frames_rx;
    logic [31:0] frames_drop;
    logic [15:0] lost_pk_now;
    logic [19:0] lost_fr_now;
    logic        tracking;
  } stats_t;

  localparam longint CNT_MAX = 64'hFFFF_FFFF;
  localparam int STALL_LIMIT = 5000;

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [47:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [167:0] out_tdata;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [1:0] cfg_index = CFG_NB;
  logic [31:0] cfg_data = '0;

  video_frame_loss_tracker_unit DUT (.*);

  always #5 clk = ~clk;

  // predictor state
  int unsigned nb_cfg = 2, gop_cfg = 12, tfc_cfg = 1048576;
  bit trk;
  logic [15:0] last_seq;
  longint good_i, good_p, cur_fn, cur_enc;
  bit fr_done, fr_drop;
  longint n_prx, n_plost, n_frx, n_fdrop;

  stats_t stats_q[$];
  int errors = 0, words_in = 0, words_out = 0, idle_cnt = 0, hold_len = 0;
  bit calm = 0;
  logic [15:0] seq_ctr;

  function automatic longint sat_add(longint a, longint b);
    return (a + b > CNT_MAX) ? CNT_MAX : a + b;
  endfunction

  function automatic longint tmod(longint a, longint m);
    return a % m;
  endfunction

  task automatic predict_stats(input logic [15:0] sq, input bit fs, input bit fe,
                               input logic [19:0] fnum, input logic [1:0] kind,
                               input bit warm);
    longint fn, nb, gop, tfc, enc, lpk, lfr, lst, nxt, top;
    bit ok;
    stats_t s;
    fn = fnum; nb = nb_cfg;
    gop = gop_cfg == 0 ? 1 : gop_cfg;
    tfc = tfc_cfg == 0 ? 1 : tfc_cfg;
    lpk = 0; lfr = 0;
    if (kind == KIND_I || kind == KIND_IDR) enc = fn == 0 ? 0 : fn - nb;
    else if (kind == KIND_P) enc = fn - nb;
    else enc = fn + 1;
    if (!trk) begin
      if (warm && (kind == KIND_I || kind == KIND_IDR) && fs) begin
        last_seq = sq;
        good_p = fn > 0 ? fn - nb - 1 : -1;
        cur_fn = fn; cur_enc = enc;
        if (fe) begin
          fr_done = 1; good_i = fn; n_frx = sat_add(n_frx, 1);
        end else begin
          fr_drop = 0; fr_done = 0; good_i = -1;
        end
        n_prx = sat_add(n_prx, 1);
        trk = 1;
      end
    end else begin
      if (sq != 16'(last_seq + 16'd1)) begin
        lpk = sq > last_seq ? longint'(sq) - longint'(last_seq) : 1;
        if (enc > tmod(cur_enc + 1, tfc)) begin
          top = enc > cur_enc ? enc : cur_enc;
          if (top - cur_enc - 1 > 0) lfr += top - cur_enc - 1;
        end
        if (!fr_done) lfr++;
        if (!fs) fr_drop = 1;
      end
      last_seq = sq;
      if (fs) begin
        if (kind == KIND_I || kind == KIND_IDR) ok = 1;
        else if (kind == KIND_P) ok = good_i == fn - nb - 1 || good_p == fn - nb - 1;
        else begin
          lst = (fn / (nb + 1)) * (nb + 1);
          nxt = lst + nb + 1;
          if (nxt % gop == 0) ok = good_p == lst && good_i == nxt;
          else ok = good_p == nxt;
        end
        fr_drop = !ok;
        fr_done = fe;
        if (fe) begin
          if (ok) begin
            if (kind == KIND_I || kind == KIND_IDR) good_i = fn;
            else if (kind == KIND_P) good_p = fn;
            n_frx = sat_add(n_frx, 1);
          end else lfr++;
        end
        cur_fn = fn; cur_enc = enc;
      end else if (fe) begin
        if (!fr_drop) begin
          if (kind == KIND_I || kind == KIND_IDR) good_i = cur_fn;
          else if (kind == KIND_P) good_p = cur_fn;
          n_frx = sat_add(n_frx, 1);
        end else lfr++;
        fr_done = 1;
      end
      n_prx = sat_add(n_prx, 1);
      n_plost = sat_add(n_plost, lpk);
      n_fdrop = sat_add(n_fdrop, lfr);
    end
    if (lfr > 20'hFFFFF) lfr = 20'hFFFFF;
    s.pkts_rx = n_prx[31:0];
    s.pkts_lost = n_plost[31:0];
    s.frames_rx = n_frx[31:0];
    s.frames_drop = n_fdrop[31:0];
    s.lost_pk_now = lpk[15:0];
    s.lost_fr_now = lfr[19:0];
    s.tracking = trk;
    stats_q = {stats_q, s};
  endtask

  task automatic send_packet(input logic [15:0] sq, input bit fs, input bit fe,
                             input logic [19:0] fn, input logic [1:0] kind,
                             input bit warm = 1);
    int gap;
    gap = calm ? 0 : ($urandom_range(99) < 35 ? $urandom_range(1, 4) : 0);
    if (gap > 0) begin
      in_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= {7'b0, warm, kind, fn, fe, fs, sq};
    do @(posedge clk); while (!in_tready);
    predict_stats(sq, fs, fe, fn, kind, warm);
    words_in++;
  endtask

  task automatic write_reg(input logic [1:0] idx, input int unsigned val);
    in_tvalid <= 0;
    while (stats_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    case (idx)
      CFG_NB:  nb_cfg = val & 32'hF;
      CFG_GOP: gop_cfg = val & 32'h7FF;
      default: tfc_cfg = val & 32'h1FFFFF;
    endcase
  endtask

  task automatic set_gop_shape(input int unsigned nb, input int unsigned gop,
                               input int unsigned tfc);
    write_reg(CFG_NB, nb);
    write_reg(CFG_GOP, gop);
    write_reg(CFG_TFC, tfc);
  endtask

  // one frame split into fragments; some fragments vanish to make sequence gaps, and stray random packets slip in
  task automatic send_frame(input int fn, input logic [1:0] kind, input int drop_pct);
    int npk;
    npk = $urandom_range(1, 3);
    for (int p = 0; p < npk; p++) begin
      if ($urandom_range(99) >= drop_pct)
        send_packet(seq_ctr, p == 0, p == npk - 1, fn[19:0], kind);
      seq_ctr++;
      if ($urandom_range(99) < 3)
        send_packet(16'($urandom), 1'($urandom_range(1)), 1'($urandom_range(1)),
                    20'($urandom), 2'($urandom), 1'($urandom_range(1)));
    end
  endtask

  // encoding-order GOP stream: anchor first, then the B frames before it
  task automatic send_stream(input int n_words, input int drop_pct);
    int start_cnt, a, base;
    logic [1:0] kind;
    start_cnt = words_in;
    base = $urandom_range(0, 3) * 64;
    a = 0;
    while (words_in - start_cnt < n_words && base + a < 1000000) begin
      if ((base + a) % (gop_cfg == 0 ? 1 : gop_cfg) == 0)
        kind = $urandom_range(1) ? KIND_IDR : KIND_I;
      else kind = KIND_P;
      send_frame(base + a, kind, drop_pct);
      if (a > 0)
        for (int b = a - int'(nb_cfg); b < a; b++) send_frame(base + b, KIND_B, drop_pct);
      a += nb_cfg + 1;
    end
  endtask

  task automatic test_sync;
    send_packet(16'd100, 1, 1, 20'd0, KIND_I, 0);
    send_packet(16'd101, 1, 1, 20'd3, KIND_P);
    send_packet(16'd102, 0, 1, 20'd0, KIND_I);
    send_packet(16'd65534, 1, 0, 20'd0, KIND_IDR);
    send_packet(16'd65535, 0, 1, 20'd0, KIND_IDR);
  endtask

  task automatic test_corners;
    send_packet(16'd0, 1, 1, 20'd3, KIND_P);
    send_packet(16'd0, 1, 1, 20'd1, KIND_B);
    send_packet(16'd5, 1, 1, 20'd2, KIND_B);
    send_packet(16'd6, 1, 1, 20'hFFFFF, KIND_I);
    send_packet(16'd7, 0, 0, 20'hFFFFF, KIND_P, 0);
    send_packet(16'd7, 1, 0, 20'd0, KIND_B);
    send_packet(16'hFFFF, 0, 1, 20'd0, KIND_B);
    send_packet(16'd2, 1, 1, 20'd12, KIND_I);
    send_packet(16'd3, 1, 1, 20'd15, KIND_P);
    seq_ctr = 16'd4;
  endtask

  task automatic test_gop_shapes;
    send_stream(150, 4);
    set_gop_shape(0, 1, 1);
    send_stream(150, 4);
    set_gop_shape(15, 1024, 1048576);
    send_stream(150, 4);
    set_gop_shape(3, 0, 0);
    send_stream(120, 6);
    set_gop_shape(1, 5, 7);
    send_stream(120, 4);
    set_gop_shape($urandom_range(15), $urandom_range(1, 30), $urandom_range(1, 100));
    send_stream(100, 4);
  endtask

  task automatic test_noise;
    for (int i = 0; i < 80; i++)
      send_packet(16'($urandom), 1'($urandom_range(1)), 1'($urandom_range(1)),
                  20'($urandom), 2'($urandom), 1'($urandom_range(1)));
    seq_ctr = 16'($urandom);
  endtask

  task automatic test_backpressure;
    calm = 1;
    hold_len = 400;
    send_stream(60, 0);
    calm = 0;
  endtask

  always @(posedge clk) begin
    if (!rst_n) out_tready <= 0;
    else if (hold_len > 0) begin
      hold_len = hold_len - 1;
      out_tready <= 0;
    end else out_tready <= calm ? 1'b1 : ($urandom_range(99) >= 35);
  end

  always @(posedge clk) begin
    stats_t e, a;
    if (rst_n && out_tvalid && out_tready) begin
      a.pkts_rx = out_tdata[31:0];
      a.pkts_lost = out_tdata[63:32];
      a.frames_rx = out_tdata[95:64];
      a.frames_drop = out_tdata[127:96];
      a.lost_pk_now = out_tdata[143:128];
      a.lost_fr_now = out_tdata[163:144];
      a.tracking = out_tdata[164];
      words_out++;
      if (stats_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result word %0d", words_out);
      end else begin
        e = stats_q.pop_front();
        if (a !== e) begin
          errors++;
          if (errors <= 10)
            $display("word %0d: exp rx=%0d lost=%0d frx=%0d fdrop=%0d lpk=%0d lfr=%0d trk=%0d",
                     words_out, e.pkts_rx, e.pkts_lost, e.frames_rx, e.frames_drop,
                     e.lost_pk_now, e.lost_fr_now, e.tracking, "\n         got rx=%0d ",
                     a.pkts_rx, "lost=%0d frx=%0d fdrop=%0d lpk=%0d lfr=%0d trk=%0d",
                     a.pkts_lost, a.frames_rx, a.frames_drop, a.lost_pk_now,
                     a.lost_fr_now, a.tracking);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= STALL_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
      $display("tb_top: errors");
      $finish;
    end
  end

  initial begin
    trk = 0; last_seq = 0; good_i = -1; good_p = -1; cur_fn = 0; cur_enc = 0;
    fr_done = 1; fr_drop = 0; n_prx = 0; n_plost = 0; n_frx = 0; n_fdrop = 0;
    seq_ctr = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    test_sync();
    test_corners();
    test_noise();
    test_gop_shapes();
    test_backpressure();
    in_tvalid <= 0;
    while (stats_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("covered %0d packets in, %0d results out: sync, wraps, gaps, noise,", words_in,
             words_out);
    $display("six GOP shapes incl. register extremes, and a long output stall");
    if (errors == 0 && stats_q.size() == 0) $display("tb_top: clean");
    else $display("tb_top: errors");
    $finish;
  end

endmodule
